>>> rtl/swlc_pkg.sv
// Shared types, default sizes and helpers for the set-associative write-back cache.
// Used by every module of the cache; depends on nothing else.
package swlc_pkg;

    localparam int NumSetsDef   = 16;
    localparam int NumWaysDef   = 4;
    localparam int LineWordsDef = 32;
    localparam int MemWordsDef  = 65536;
    localparam int DataWidthDef = 32;

    localparam int CmdW = 2;
    localparam int CntW = 16;
    localparam int OutW = 32;

    typedef enum logic [CmdW-1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    // Control group for the tag and line-data memories.
    typedef struct packed {
        logic tag_rd;
        logic tag_wr;
        logic data_rd;
        logic data_wr;
    } t_ls_ctrl;

    // Control group for the backing main memory.
    typedef struct packed {
        logic rd;
        logic wr;
    } t_mm_ctrl;

    function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
        sat_inc = (v == {CntW{1'b1}}) ? v : v + {{(CntW-1){1'b0}}, 1'b1};
    endfunction

endpackage

>>> rtl/swlc_main_mem.sv
// Word-addressed main memory behind the cache, single port, with a registered read output.
// After reset a clearing pass loads every word with its own address. Uses swlc_pkg.
module swlc_main_mem #(
    parameter int MEM_WORDS  = swlc_pkg::MemWordsDef,
    parameter int DATA_WIDTH = swlc_pkg::DataWidthDef
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  swlc_pkg::t_mm_ctrl           i_ctrl,
    input  logic [$clog2(MEM_WORDS)-1:0] i_addr,
    input  logic [DATA_WIDTH-1:0]        i_wdata,
    output logic [DATA_WIDTH-1:0]        o_q,
    output logic                         o_ready
);
    localparam int AW = $clog2(MEM_WORDS);

    logic [DATA_WIDTH-1:0] r_mem [MEM_WORDS];
    logic [AW-1:0]         r_clr_addr;
    logic                  r_clr_busy;
    logic [DATA_WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == {AW{1'b1}}) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= DATA_WIDTH'(r_clr_addr);
        end else if (i_ctrl.wr) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctrl.rd) begin
            r_q <= r_mem[i_addr];
        end
    end

    assign o_q     = r_q;
    assign o_ready = !r_clr_busy;

endmodule

>>> rtl/swlc_line_store.sv
// Tag memory (one row of all ways per set) and line-data memory of the cache.
// Both are synchronous with registered read outputs. Uses swlc_pkg.
module swlc_line_store #(
    parameter int NUM_SETS   = swlc_pkg::NumSetsDef,
    parameter int NUM_WAYS   = swlc_pkg::NumWaysDef,
    parameter int LINE_WORDS = swlc_pkg::LineWordsDef,
    parameter int TAG_W      = 7,
    parameter int DATA_WIDTH = swlc_pkg::DataWidthDef
) (
    input  logic                                                 i_clk,
    input  swlc_pkg::t_ls_ctrl                                   i_ctrl,
    input  logic [$clog2(NUM_SETS)-1:0]                          i_tag_set,
    input  logic [NUM_WAYS-1:0][TAG_W-1:0]                       i_tag_row,
    output logic [NUM_WAYS-1:0][TAG_W-1:0]                       o_tag_row,
    input  logic [$clog2(NUM_SETS*NUM_WAYS*LINE_WORDS)-1:0]      i_rd_addr,
    input  logic [$clog2(NUM_SETS*NUM_WAYS*LINE_WORDS)-1:0]      i_wr_addr,
    input  logic [DATA_WIDTH-1:0]                                i_wdata,
    output logic [DATA_WIDTH-1:0]                                o_q
);
    localparam int DEPTH = NUM_SETS * NUM_WAYS * LINE_WORDS;

    logic [NUM_WAYS-1:0][TAG_W-1:0] r_tags [NUM_SETS];
    logic [DATA_WIDTH-1:0]          r_data [DEPTH];
    logic [NUM_WAYS-1:0][TAG_W-1:0] r_tag_q;
    logic [DATA_WIDTH-1:0]          r_q;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.tag_wr) begin
            r_tags[i_tag_set] <= i_tag_row;
        end
        if (i_ctrl.tag_rd) begin
            r_tag_q <= r_tags[i_tag_set];
        end
        if (i_ctrl.data_wr) begin
            r_data[i_wr_addr] <= i_wdata;
        end
        if (i_ctrl.data_rd) begin
            r_q <= r_data[i_rd_addr];
        end
    end

    assign o_tag_row = r_tag_q;
    assign o_q       = r_q;

endmodule

>>> rtl/set_assoc_writeback_lru_cache_core.sv
// Top level of the set-associative write-back cache with true LRU replacement.
// Instantiates swlc_line_store and swlc_main_mem; uses swlc_pkg.
//
//  Channel  | Valid    | Stall    | Payload
//  request  | i_valid  | o_stall  | i_command, i_address, i_write_data
//  result   | o_valid  | i_stall  | o_read_data, o_hit, o_wrote_back, o_*_count
//
// A read hit passes the tag read, the lookup, the data memory read and its result
// register; a write hit skips the last. A miss adds a line fill from main memory and,
// with a dirty victim, a write-back ahead of it; both move one word a cycle.
// A flush reads the tags of each set, checks each way and writes back every dirty line.
// After reset o_stall stays high while the main memory clearing pass runs.
// A finished result waits in the output register while the next request is taken.
module set_assoc_writeback_lru_cache_core #(
    parameter int NUM_SETS   = swlc_pkg::NumSetsDef,
    parameter int NUM_WAYS   = swlc_pkg::NumWaysDef,
    parameter int LINE_WORDS = swlc_pkg::LineWordsDef,
    parameter int MEM_WORDS  = swlc_pkg::MemWordsDef,
    parameter int DATA_WIDTH = swlc_pkg::DataWidthDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_address,
    input  logic [31:0] i_write_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_read_data,
    output logic        o_hit,
    output logic        o_wrote_back,
    output logic [15:0] o_read_hit_count,
    output logic [15:0] o_read_miss_count,
    output logic [15:0] o_write_hit_count,
    output logic [15:0] o_write_miss_count,
    output logic [15:0] o_writeback_count
);
    localparam int OFF_W  = $clog2(LINE_WORDS);
    localparam int SET_W  = $clog2(NUM_SETS);
    localparam int WAY_W  = $clog2(NUM_WAYS);
    localparam int MEM_AW = $clog2(MEM_WORDS);
    localparam int TAG_W  = MEM_AW - OFF_W - SET_W;
    localparam int LN_W   = $clog2(NUM_SETS * NUM_WAYS);
    localparam int DA_W   = $clog2(NUM_SETS * NUM_WAYS * LINE_WORDS);
    localparam int K_W    = OFF_W + 1;
    localparam int CNT_W  = swlc_pkg::CntW;
    localparam int OUT_W  = swlc_pkg::OutW;

    typedef enum logic [3:0] {
        S_IDLE, S_TREQ, S_LOOK, S_WB, S_FILL, S_ACC, S_RDQ,
        S_FTAG, S_FLOOK, S_FWAY, S_FNEXT, S_DONE
    } t_state;

    t_state                         r_state;
    swlc_pkg::t_cmd                 r_cmd;
    logic [TAG_W-1:0]               r_tag;
    logic [SET_W-1:0]               r_set;
    logic [OFF_W-1:0]               r_off;
    logic [OUT_W-1:0]               r_wdata;
    logic [WAY_W-1:0]               r_way;
    logic [TAG_W-1:0]               r_wb_tag;
    logic [NUM_WAYS-1:0][TAG_W-1:0] r_tags;
    logic [K_W-1:0]                 r_k;
    logic [OFF_W-1:0]               r_kd;
    logic                           r_pend;
    logic                           r_hit;
    logic                           r_wb_flag;
    logic [OUT_W-1:0]               r_rdata;

    logic [NUM_WAYS-1:0]            r_valid [NUM_SETS];
    logic [NUM_WAYS-1:0]            r_dirty [NUM_SETS];
    logic [WAY_W-1:0]               r_rank  [NUM_SETS][NUM_WAYS];

    logic [CNT_W-1:0] r_rd_hits, r_rd_miss, r_wr_hits, r_wr_miss, r_wbs;

    logic             r_out_valid;
    logic [OUT_W-1:0] r_o_rdata;
    logic             r_o_hit, r_o_wb;
    logic [CNT_W-1:0] r_o_rh, r_o_rm, r_o_wh, r_o_wm, r_o_wbc;

    swlc_pkg::t_ls_ctrl             w_ls_ctrl;
    swlc_pkg::t_mm_ctrl             w_mm_ctrl;
    logic [NUM_WAYS-1:0][TAG_W-1:0] w_tag_q;
    logic [NUM_WAYS-1:0][TAG_W-1:0] w_tag_row;
    logic [DA_W-1:0]                w_rd_addr, w_wr_addr;
    logic [DATA_WIDTH-1:0]          w_ls_wdata, w_ls_q;
    logic [MEM_AW-1:0]              w_mm_addr;
    logic [DATA_WIDTH-1:0]          w_mm_q;
    logic                           w_mm_ready;

    logic [MEM_AW-1:0]   w_maddr;
    logic [LN_W-1:0]     w_line;
    logic                w_k_run, w_k_end;
    logic [NUM_WAYS-1:0] w_hit_vec, w_lru_vec;
    logic                w_found;
    logic [WAY_W-1:0]    w_found_way, w_inv_way, w_lru_way, w_victim;
    logic                w_have_inv;
    logic                w_accept;

    assign w_maddr  = MEM_AW'(i_address);
    assign w_line   = LN_W'(LN_W'(r_set) * LN_W'(NUM_WAYS) + LN_W'(r_way));
    assign w_k_run  = (r_k < K_W'(LINE_WORDS));
    assign w_k_end  = (r_k == K_W'(LINE_WORDS));
    assign o_stall  = (r_state != S_IDLE) || !w_mm_ready;
    assign w_accept = i_valid && !o_stall;

    // Tag compare, victim choice and LRU way for the set being looked up.
    always_comb begin
        w_found     = 1'b0;
        w_found_way = '0;
        w_have_inv  = 1'b0;
        w_inv_way   = '0;
        w_lru_way   = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            w_hit_vec[w] = r_valid[r_set][w] && (w_tag_q[w] == r_tag);
            w_lru_vec[w] = (r_rank[r_set][w] == WAY_W'(NUM_WAYS - 1));
            if (!r_valid[r_set][w]) begin
                w_have_inv = 1'b1;
                w_inv_way  = WAY_W'(w);
            end
            if (w_lru_vec[w]) begin
                w_lru_way = WAY_W'(w);
            end
        end
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (w_hit_vec[w]) begin
                w_found     = 1'b1;
                w_found_way = WAY_W'(w);
            end
        end
        w_victim = w_have_inv ? w_inv_way : w_lru_way;
    end

    always_comb begin
        w_ls_ctrl  = '0;
        w_mm_ctrl  = '0;
        w_rd_addr  = {w_line, r_k[OFF_W-1:0]};
        w_wr_addr  = {w_line, r_kd};
        w_ls_wdata = w_mm_q;
        w_mm_addr  = {r_tag, r_set, r_k[OFF_W-1:0]};
        w_tag_row  = r_tags;
        w_tag_row[r_way] = r_tag;
        case (r_state)
            S_TREQ, S_FTAG: begin
                w_ls_ctrl.tag_rd = 1'b1;
            end
            S_WB: begin
                w_ls_ctrl.data_rd = w_k_run;
                w_mm_ctrl.wr      = r_pend;
                w_mm_addr         = {r_wb_tag, r_set, r_kd};
            end
            S_FILL: begin
                w_mm_ctrl.rd      = w_k_run;
                w_ls_ctrl.data_wr = r_pend;
                w_ls_ctrl.tag_wr  = w_k_end;
            end
            S_ACC: begin
                if (r_cmd == swlc_pkg::CMD_READ) begin
                    w_ls_ctrl.data_rd = 1'b1;
                    w_rd_addr         = {w_line, r_off};
                end else begin
                    w_ls_ctrl.data_wr = 1'b1;
                    w_wr_addr         = {w_line, r_off};
                    w_ls_wdata        = DATA_WIDTH'(r_wdata);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_set       <= '0;
            r_out_valid <= 1'b0;
            r_rd_hits   <= '0;
            r_rd_miss   <= '0;
            r_wr_hits   <= '0;
            r_wr_miss   <= '0;
            r_wbs       <= '0;
            for (int s = 0; s < NUM_SETS; s++) begin
                r_valid[s] <= '0;
                r_dirty[s] <= '0;
                for (int w = 0; w < NUM_WAYS; w++) begin
                    r_rank[s][w] <= WAY_W'(w);
                end
            end
        end else begin
            if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd     <= swlc_pkg::t_cmd'(i_command);
                        r_tag     <= w_maddr[MEM_AW-1 -: TAG_W];
                        r_set     <= w_maddr[OFF_W +: SET_W];
                        r_off     <= w_maddr[OFF_W-1:0];
                        r_wdata   <= i_write_data;
                        r_hit     <= 1'b0;
                        r_wb_flag <= 1'b0;
                        r_rdata   <= '0;
                        case (swlc_pkg::t_cmd'(i_command))
                            swlc_pkg::CMD_FLUSH: begin
                                r_set   <= '0;
                                r_state <= S_FTAG;
                            end
                            swlc_pkg::CMD_NOP: r_state <= S_DONE;
                            default:           r_state <= S_TREQ;
                        endcase
                    end
                end
                S_TREQ: r_state <= S_LOOK;
                S_LOOK: begin
                    r_tags <= w_tag_q;
                    r_hit  <= w_found;
                    r_k    <= '0;
                    r_pend <= 1'b0;
                    if (w_found) begin
                        r_way   <= w_found_way;
                        r_state <= S_ACC;
                    end else begin
                        r_way    <= w_victim;
                        r_wb_tag <= w_tag_q[w_victim];
                        if (r_valid[r_set][w_victim] && r_dirty[r_set][w_victim]) begin
                            r_state <= S_WB;
                        end else begin
                            r_state <= S_FILL;
                        end
                    end
                end
                S_WB, S_FILL: begin
                    // Reads run one word ahead of the writes they feed.
                    r_k    <= r_k + 1'b1;
                    r_kd   <= r_k[OFF_W-1:0];
                    r_pend <= w_k_run;
                    if (w_k_end) begin
                        r_k    <= '0;
                        r_pend <= 1'b0;
                        if (r_state == S_WB) begin
                            r_dirty[r_set][r_way] <= 1'b0;
                            r_wbs     <= swlc_pkg::sat_inc(r_wbs);
                            r_wb_flag <= 1'b1;
                            r_state   <= (r_cmd == swlc_pkg::CMD_FLUSH) ? S_FNEXT : S_FILL;
                        end else begin
                            r_valid[r_set][r_way] <= 1'b1;
                            r_dirty[r_set][r_way] <= 1'b0;
                            r_tags  <= w_tag_row;
                            r_state <= S_ACC;
                        end
                    end
                end
                S_ACC: begin
                    if (r_cmd == swlc_pkg::CMD_READ) begin
                        r_state <= S_RDQ;
                    end else begin
                        r_rdata <= OUT_W'(DATA_WIDTH'(r_wdata));
                        r_dirty[r_set][r_way] <= 1'b1;
                        if (r_hit) begin
                            r_wr_hits <= swlc_pkg::sat_inc(r_wr_hits);
                        end else begin
                            r_wr_miss <= swlc_pkg::sat_inc(r_wr_miss);
                        end
                        for (int w = 0; w < NUM_WAYS; w++) begin
                            if (WAY_W'(w) == r_way) begin
                                r_rank[r_set][w] <= '0;
                            end else if (r_rank[r_set][w] < r_rank[r_set][r_way]) begin
                                r_rank[r_set][w] <= r_rank[r_set][w] + 1'b1;
                            end
                        end
                        r_state <= S_DONE;
                    end
                end
                S_RDQ: begin
                    r_rdata <= OUT_W'(w_ls_q);
                    if (r_hit) begin
                        r_rd_hits <= swlc_pkg::sat_inc(r_rd_hits);
                    end else begin
                        r_rd_miss <= swlc_pkg::sat_inc(r_rd_miss);
                    end
                    for (int w = 0; w < NUM_WAYS; w++) begin
                        if (WAY_W'(w) == r_way) begin
                            r_rank[r_set][w] <= '0;
                        end else if (r_rank[r_set][w] < r_rank[r_set][r_way]) begin
                            r_rank[r_set][w] <= r_rank[r_set][w] + 1'b1;
                        end
                    end
                    r_state <= S_DONE;
                end
                S_FTAG: r_state <= S_FLOOK;
                S_FLOOK: begin
                    r_tags  <= w_tag_q;
                    r_way   <= '0;
                    r_state <= S_FWAY;
                end
                S_FWAY: begin
                    r_k      <= '0;
                    r_pend   <= 1'b0;
                    r_wb_tag <= r_tags[r_way];
                    if (r_valid[r_set][r_way] && r_dirty[r_set][r_way]) begin
                        r_state <= S_WB;
                    end else begin
                        r_state <= S_FNEXT;
                    end
                end
                S_FNEXT: begin
                    r_valid[r_set][r_way] <= 1'b0;
                    r_dirty[r_set][r_way] <= 1'b0;
                    if (r_way == WAY_W'(NUM_WAYS - 1)) begin
                        if (r_set == SET_W'(NUM_SETS - 1)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_set   <= r_set + 1'b1;
                            r_state <= S_FTAG;
                        end
                    end else begin
                        r_way   <= r_way + 1'b1;
                        r_state <= S_FWAY;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_o_rdata   <= r_rdata;
                        r_o_hit     <= r_hit;
                        r_o_wb      <= r_wb_flag;
                        if (r_cmd == swlc_pkg::CMD_NOP) begin
                            r_o_rh  <= '0;
                            r_o_rm  <= '0;
                            r_o_wh  <= '0;
                            r_o_wm  <= '0;
                            r_o_wbc <= '0;
                        end else begin
                            r_o_rh  <= r_rd_hits;
                            r_o_rm  <= r_rd_miss;
                            r_o_wh  <= r_wr_hits;
                            r_o_wm  <= r_wr_miss;
                            r_o_wbc <= r_wbs;
                        end
                        // A flush reports the counters and then clears them.
                        if (r_cmd == swlc_pkg::CMD_FLUSH) begin
                            r_rd_hits <= '0;
                            r_rd_miss <= '0;
                            r_wr_hits <= '0;
                            r_wr_miss <= '0;
                            r_wbs     <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    swlc_line_store #(
        .NUM_SETS   (NUM_SETS),
        .NUM_WAYS   (NUM_WAYS),
        .LINE_WORDS (LINE_WORDS),
        .TAG_W      (TAG_W),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_ctrl    (w_ls_ctrl),
        .i_tag_set (r_set),
        .i_tag_row (w_tag_row),
        .o_tag_row (w_tag_q),
        .i_rd_addr (w_rd_addr),
        .i_wr_addr (w_wr_addr),
        .i_wdata   (w_ls_wdata),
        .o_q       (w_ls_q)
    );

    swlc_main_mem #(
        .MEM_WORDS  (MEM_WORDS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_main_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_mm_ctrl),
        .i_addr  (w_mm_addr),
        .i_wdata (w_ls_q),
        .o_q     (w_mm_q),
        .o_ready (w_mm_ready)
    );

    assign o_valid            = r_out_valid;
    assign o_read_data        = r_o_rdata;
    assign o_hit              = r_o_hit;
    assign o_wrote_back       = r_o_wb;
    assign o_read_hit_count   = r_o_rh;
    assign o_read_miss_count  = r_o_rm;
    assign o_write_hit_count  = r_o_wh;
    assign o_write_miss_count = r_o_wm;
    assign o_writeback_count  = r_o_wbc;

    // No request is worked on while the main memory is still being cleared.
    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_mm_ready |-> r_state == S_IDLE)
        else $error("request in progress during main memory clearing");

    // A line can only be dirty while it is valid.
    a_dirty_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dirty[r_set] & ~r_valid[r_set]) == '0)
        else $error("dirty bit set on an invalid line");

    // The ranks of a set stay a permutation, so exactly one way is least recent.
    a_one_lru: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_lru_vec) == 1)
        else $error("set without a single LRU way");

    // Lines are only filled on a miss, so a tag matches in at most one way.
    a_one_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LOOK |-> $onehot0(w_hit_vec))
        else $error("tag matches in more than one way");

endmodule
